FILE: rtl/core/stdpwu_pkg.sv
// Shared types, constants and decay table for the STDP weight update block.
`timescale 1ns / 1ps
`default_nettype none

package stdpwu_pkg;

  // Fixed point and field widths
  localparam int FRAC_BITS         = 20;
  localparam int DECAY_TABLE_DEPTH = 256;
  localparam int WEIGHT_W          = 24;
  localparam int TIME_W            = 20;
  localparam int AMP_W             = 21;
  localparam int WIN_W             = 8;
  localparam int FLOOR_W           = 20;
  localparam int MODE_W            = 2;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 21;

  // Datapath widths
  localparam int DT_W              = TIME_W + 1;
  localparam int DECAY_INDEX_COUNT = 1 << WIN_W;
  localparam int DECAY_W           = FRAC_BITS + 1;
  localparam int PW_W              = 49;                 // w * (1 - w)
  localparam int P_W               = 28;                 // rounded w * (1 - w)
  localparam int TERM_PROD_W       = AMP_W + DECAY_W;    // amplitude * decay
  localparam int TERM_W            = 22;
  localparam int DP_W              = TERM_W + 1 + P_W;   // term * p
  localparam int DELTA_W           = 31;
  localparam int STEP_W            = DELTA_W + 1;
  localparam int RES_W             = 33;

  // Cycles from an accepted start to its done strobe
  localparam int LATENCY           = 6;

  localparam logic [63:0] DECAY_STEP_Q32 = 64'd3516421809;

  localparam logic signed [WEIGHT_W:0] ONE_FIX = (WEIGHT_W + 1)'(1) << FRAC_BITS;
  localparam logic signed [RES_W-1:0]  W_MAX   = RES_W'(2 ** (WEIGHT_W - 1) - 1);
  localparam logic signed [RES_W-1:0]  W_MIN   = RES_W'(-(2 ** (WEIGHT_W - 1)));

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RULE_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POT_AMP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEP_AMP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POT_WIN     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEP_WIN     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGN_FLOOR  = 3'd5;

  // Rule modes; the unused code behaves as additive
  localparam logic [MODE_W-1:0] RULE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] RULE_MULT = 2'd1;
  localparam logic [MODE_W-1:0] RULE_ANTI = 2'd2;

  // Reset values
  localparam logic [MODE_W-1:0]  RST_RULE_MODE  = RULE_ADD;
  localparam logic [AMP_W-1:0]   RST_POT_AMP    = 21'd10486;
  localparam logic [AMP_W-1:0]   RST_DEP_AMP    = 21'd10486;
  localparam logic [WIN_W-1:0]   RST_POT_WIN    = 8'd75;
  localparam logic [WIN_W-1:0]   RST_DEP_WIN    = 8'd200;
  localparam logic [FLOOR_W-1:0] RST_SIGN_FLOOR = 20'd105;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [TIME_W-1:0]          pre_spike_time;
    logic                       pre_valid;
    logic [TIME_W-1:0]          post_spike_time;
    logic                       post_valid;
  } stdp_in_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] new_weight;
    logic                       changed;
    logic                       saturated;
  } stdp_out_t;

  typedef struct packed {
    logic [MODE_W-1:0]  rule_mode;
    logic [AMP_W-1:0]   pot_amp;
    logic [AMP_W-1:0]   dep_amp;
    logic [WIN_W-1:0]   pot_win;
    logic [WIN_W-1:0]   dep_win;
    logic [FLOOR_W-1:0] sign_floor;
  } stdp_cfg_t;

  // Control that travels down the pipe with each word
  typedef struct packed {
    logic valid;
    logic pot;
    logic dep;
  } stage_ctl_t;

  typedef logic [DECAY_W-1:0] decay_rom_t [DECAY_INDEX_COUNT];

  // exp(-k/5) in Q1.F, built by repeated Q32 multiplication
  function automatic decay_rom_t build_decay_rom();
    decay_rom_t  rom;
    logic [63:0] e;
    e = 64'd1 << 32;
    for (int k = 0; k < DECAY_INDEX_COUNT; k++) begin
      if (k < DECAY_TABLE_DEPTH) begin
        rom[k] = DECAY_W'((e + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
      end else begin
        rom[k] = '0;
      end
      e = (e * DECAY_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam decay_rom_t DECAY_ROM = build_decay_rom();

endpackage

`default_nettype wire

FILE: rtl/core/stdpwu_timing.sv
// Stages 1-2: spike time difference, window check, decay lookup and w*(1-w).
`timescale 1ns / 1ps
`default_nettype none

module stdpwu_timing (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        accept,
  input  stdpwu_pkg::stdp_in_t                        item,
  input  stdpwu_pkg::stdp_cfg_t                       cfg,
  output stdpwu_pkg::stage_ctl_t                      s2_ctl,
  output logic signed [stdpwu_pkg::WEIGHT_W-1:0]      s2_weight,
  output logic signed [stdpwu_pkg::P_W-1:0]           s2_p,
  output logic [stdpwu_pkg::DECAY_W-1:0]              s2_decay,
  output logic [stdpwu_pkg::AMP_W-1:0]                s2_amp
);
  import stdpwu_pkg::*;

  localparam logic signed [PW_W-1:0] PW_HALF = PW_W'(1) << (FRAC_BITS - 1);

  // Stage 1
  logic                       v1;
  logic                       both1;
  logic signed [DT_W-1:0]     dt1;
  logic signed [WEIGHT_W-1:0] w1;
  logic signed [PW_W-1:0]     prod_w1;

  logic signed [WEIGHT_W:0]   one_minus_w;
  logic signed [DT_W-1:0]     dt;
  logic signed [PW_W-1:0]     prod_w;

  assign dt          = {1'b0, item.post_spike_time} - {1'b0, item.pre_spike_time};
  assign one_minus_w = ONE_FIX - (WEIGHT_W + 1)'(item.weight);
  assign prod_w      = PW_W'(item.weight) * PW_W'(one_minus_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    both1   <= item.pre_valid & item.post_valid;
    dt1     <= dt;
    w1      <= item.weight;
    prod_w1 <= prod_w;
  end

  // Stage 2
  logic [DT_W-1:0]        mag;
  logic                   pot;
  logic                   dep;
  logic signed [PW_W-1:0] pw_round;

  always_comb begin
    mag = dt1[DT_W-1] ? (DT_W'(0) - dt1) : dt1;
    pot = both1 && !dt1[DT_W-1] && (dt1 != '0) && (mag < DT_W'(cfg.pot_win));
    dep = both1 && dt1[DT_W-1] && (mag < DT_W'(cfg.dep_win));
  end

  assign pw_round = prod_w1 + PW_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else begin
      s2_ctl.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl.pot <= pot;
    s2_ctl.dep <= dep;
    s2_weight  <= w1;
    s2_p       <= pw_round[FRAC_BITS+P_W-1:FRAC_BITS];
    // Index is in range whenever a window is hit
    s2_decay   <= DECAY_ROM[mag[WIN_W-1:0]];
    s2_amp     <= pot ? cfg.pot_amp : cfg.dep_amp;
  end

  a_one_window: assert property (@(posedge clk) disable iff (rst)
    s2_ctl.valid |-> $onehot0({s2_ctl.pot, s2_ctl.dep}))
    else $error("potentiation and depression both set");

  a_no_window_without_time: assert property (@(posedge clk) disable iff (rst)
    v1 && !both1 |=> !s2_ctl.pot && !s2_ctl.dep)
    else $error("window hit without both spike times valid");

endmodule

`default_nettype wire

FILE: rtl/core/stdpwu_scale.sv
// Stages 3-5: amplitude times decay, multiplicative scaling and signed step.
`timescale 1ns / 1ps
`default_nettype none

module stdpwu_scale (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [stdpwu_pkg::MODE_W-1:0]               rule_mode,
  input  stdpwu_pkg::stage_ctl_t                      s2_ctl,
  input  logic signed [stdpwu_pkg::WEIGHT_W-1:0]      s2_weight,
  input  logic signed [stdpwu_pkg::P_W-1:0]           s2_p,
  input  logic [stdpwu_pkg::DECAY_W-1:0]              s2_decay,
  input  logic [stdpwu_pkg::AMP_W-1:0]                s2_amp,
  output stdpwu_pkg::stage_ctl_t                      s5_ctl,
  output logic signed [stdpwu_pkg::WEIGHT_W-1:0]      s5_weight,
  output logic signed [stdpwu_pkg::STEP_W-1:0]        s5_step
);
  import stdpwu_pkg::*;

  localparam logic [TERM_PROD_W-1:0] TERM_HALF = TERM_PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DP_W-1:0] DP_HALF   = DP_W'(1) << (FRAC_BITS - 1);

  // Stage 3: amplitude * decay
  stage_ctl_t                 ctl3;
  logic signed [WEIGHT_W-1:0] w3;
  logic signed [P_W-1:0]      p3;
  logic [TERM_PROD_W-1:0]     term_prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl3.pot   <= s2_ctl.pot;
    ctl3.dep   <= s2_ctl.dep;
    w3         <= s2_weight;
    p3         <= s2_p;
    term_prod3 <= TERM_PROD_W'(s2_amp) * TERM_PROD_W'(s2_decay);
  end

  // Stage 4: round term, then term * p
  stage_ctl_t                 ctl4;
  logic signed [WEIGHT_W-1:0] w4;
  logic [TERM_W-1:0]          term4;
  logic signed [DP_W-1:0]     dprod4;

  logic [TERM_PROD_W-1:0]     term_round;
  logic [TERM_W-1:0]          term;
  logic signed [TERM_W:0]     term_s;

  always_comb begin
    term_round = term_prod3 + TERM_HALF;
    term       = term_round[FRAC_BITS+TERM_W-1:FRAC_BITS];
    term_s     = {1'b0, term};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.valid <= 1'b0;
    end else begin
      ctl4.valid <= ctl3.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl4.pot <= ctl3.pot;
    ctl4.dep <= ctl3.dep;
    w4       <= w3;
    term4    <= term;
    dprod4   <= DP_W'(term_s) * DP_W'(p3);
  end

  // Stage 5: pick the step and its sign
  logic signed [DP_W-1:0]    dp_round;
  logic signed [DELTA_W-1:0] delta;
  logic                      up;
  logic signed [STEP_W-1:0]  step;

  always_comb begin
    dp_round = dprod4 + DP_HALF;
    if (rule_mode == RULE_MULT) begin
      delta = dp_round[FRAC_BITS+DELTA_W-1:FRAC_BITS];
    end else begin
      delta = DELTA_W'(term4);
    end
    // Anti mode swaps the direction of both windows
    up   = ctl4.pot ^ (rule_mode == RULE_ANTI);
    step = up ? STEP_W'(delta) : (STEP_W'(0) - STEP_W'(delta));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctl.valid <= 1'b0;
    end else begin
      s5_ctl.valid <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_ctl.pot <= ctl4.pot;
    s5_ctl.dep <= ctl4.dep;
    s5_weight  <= w4;
    s5_step    <= step;
  end

endmodule

`default_nettype wire

FILE: rtl/core/stdpwu_apply.sv
// Stage 6: add the step, pin sign flips, clip and register the result word.
`timescale 1ns / 1ps
`default_nettype none

module stdpwu_apply (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [stdpwu_pkg::FLOOR_W-1:0]              sign_floor,
  input  stdpwu_pkg::stage_ctl_t                      s5_ctl,
  input  logic signed [stdpwu_pkg::WEIGHT_W-1:0]      s5_weight,
  input  logic signed [stdpwu_pkg::STEP_W-1:0]        s5_step,
  output logic                                        done,
  output stdpwu_pkg::stdp_out_t                       result
);
  import stdpwu_pkg::*;

  logic signed [RES_W-1:0] sum;
  logic signed [RES_W-1:0] pinned;
  logic                    w_pos;
  logic                    w_neg;
  logic                    sum_pos;
  logic                    sum_neg;
  stdp_out_t               result_next;

  always_comb begin
    sum     = RES_W'(s5_weight) + RES_W'(s5_step);
    w_neg   = s5_weight[WEIGHT_W-1];
    w_pos   = !w_neg && (s5_weight != '0);
    sum_neg = sum[RES_W-1];
    sum_pos = !sum_neg && (sum != '0);

    pinned = sum;
    if (s5_ctl.pot && w_pos && sum_neg) begin
      pinned = RES_W'(sign_floor);
    end
    if (s5_ctl.dep && w_neg && sum_pos) begin
      pinned = RES_W'(0) - RES_W'(sign_floor);
    end

    result_next.new_weight = s5_weight;
    result_next.changed    = 1'b0;
    result_next.saturated  = 1'b0;
    if (s5_ctl.pot || s5_ctl.dep) begin
      result_next.changed = 1'b1;
      if (pinned > W_MAX) begin
        result_next.new_weight = W_MAX[WEIGHT_W-1:0];
        result_next.saturated  = 1'b1;
      end else if (pinned < W_MIN) begin
        result_next.new_weight = W_MIN[WEIGHT_W-1:0];
        result_next.saturated  = 1'b1;
      end else begin
        result_next.new_weight = pinned[WEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |->
      (result.new_weight == W_MAX[WEIGHT_W-1:0]) ||
      (result.new_weight == W_MIN[WEIGHT_W-1:0]))
    else $error("saturated word not at a range limit");

  a_sat_needs_change: assert property (@(posedge clk) disable iff (rst)
    done && !result.changed |-> !result.saturated)
    else $error("saturated without an update");

endmodule

`default_nettype wire

FILE: rtl/core/stdp_weight_update_top.sv
// Top level: configuration registers and the six-stage STDP weight update pipe.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | start, busy            | item (stdp_in_t)
//   result   | done (one-cycle pulse) | result (stdp_out_t)
//   config   | cfg_we                 | cfg_index, cfg_data
//
// One word enters per cycle. Its result and done rise together from the register of
// the final stage, in stdpwu_apply, where the word is taken. The depth is set
// by the two multiplier stages for w*(1-w) and amplitude*decay feeding the
// term*p multiplier, plus window check, rounding and the final add/clip.
// busy is high only during reset. The receiver cannot stall, so the pipe
// never holds; reset clears the valid bits and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module stdp_weight_update_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  stdpwu_pkg::stdp_in_t                  item,
  output logic                                  done,
  output stdpwu_pkg::stdp_out_t                 result,
  input  logic                                  cfg_we,
  input  logic [stdpwu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [stdpwu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import stdpwu_pkg::*;

  stdp_cfg_t cfg;
  logic      accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rule_mode  <= RST_RULE_MODE;
      cfg.pot_amp    <= RST_POT_AMP;
      cfg.dep_amp    <= RST_DEP_AMP;
      cfg.pot_win    <= RST_POT_WIN;
      cfg.dep_win    <= RST_DEP_WIN;
      cfg.sign_floor <= RST_SIGN_FLOOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RULE_MODE:  cfg.rule_mode  <= cfg_data[MODE_W-1:0];
        REG_POT_AMP:    cfg.pot_amp    <= cfg_data[AMP_W-1:0];
        REG_DEP_AMP:    cfg.dep_amp    <= cfg_data[AMP_W-1:0];
        REG_POT_WIN:    cfg.pot_win    <= cfg_data[WIN_W-1:0];
        REG_DEP_WIN:    cfg.dep_win    <= cfg_data[WIN_W-1:0];
        REG_SIGN_FLOOR: cfg.sign_floor <= cfg_data[FLOOR_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  stage_ctl_t                 s2_ctl;
  logic signed [WEIGHT_W-1:0] s2_weight;
  logic signed [P_W-1:0]      s2_p;
  logic [DECAY_W-1:0]         s2_decay;
  logic [AMP_W-1:0]           s2_amp;

  stage_ctl_t                 s5_ctl;
  logic signed [WEIGHT_W-1:0] s5_weight;
  logic signed [STEP_W-1:0]   s5_step;

  stdpwu_timing u_timing (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg       (cfg),
    .s2_ctl    (s2_ctl),
    .s2_weight (s2_weight),
    .s2_p      (s2_p),
    .s2_decay  (s2_decay),
    .s2_amp    (s2_amp)
  );

  stdpwu_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .rule_mode (cfg.rule_mode),
    .s2_ctl    (s2_ctl),
    .s2_weight (s2_weight),
    .s2_p      (s2_p),
    .s2_decay  (s2_decay),
    .s2_amp    (s2_amp),
    .s5_ctl    (s5_ctl),
    .s5_weight (s5_weight),
    .s5_step   (s5_step)
  );

  stdpwu_apply u_apply (
    .clk        (clk),
    .rst        (rst),
    .sign_floor (cfg.sign_floor),
    .s5_ctl     (s5_ctl),
    .s5_weight  (s5_weight),
    .s5_step    (s5_step),
    .done       (done),
    .result     (result)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("done without a start six cycles earlier");

endmodule

`default_nettype wire

FILE: dv/stdp_weight_update_top_tb.sv
// Self-checking testbench for the STDP weight update pipe: directed table, then random phases.
`timescale 1ns / 1ps

module stdp_weight_update_top_tb;
  import stdpwu_pkg::*;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          WORDS_PER_PHASE = 156;
  localparam int          MAX_REPORTS     = 100;
  localparam longint      WEIGHT_HI       = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
  localparam longint      WEIGHT_LO       = -(longint'(1) <<< (WEIGHT_W - 1));
  localparam logic [63:0] EXP_STEP_Q32    = 64'd3516421809;  // exp(-1/5) in Q32

  typedef struct {
    bit                     is_reg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    stdp_in_t               word;
    bit                     typed;
    stdp_out_t              typed_res;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  stdp_in_t               item = '0;
  logic                   done;
  stdp_out_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  stdp_cfg_t  model_cfg;
  longint     decay_q20 [DECAY_INDEX_COUNT];
  stdp_out_t  expected_updates [$];
  stdp_out_t  oldest_update;
  plan_row_t  directed_plan [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         idle_pct = 0;

  stdp_weight_update_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stdp_weight_update_top_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  // Round x / 2^F to nearest, halves toward +inf
  function automatic longint round_q20(longint x);
    return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic stdp_out_t predict_update(stdp_in_t word);
    longint    wt, dt, mag, term, delta, sgn, res, pw;
    bit        pot, dep, chg, sat;
    stdp_out_t upd;
    wt  = $signed(word.weight);
    dt  = longint'(word.post_spike_time) - longint'(word.pre_spike_time);
    pot = word.pre_valid && word.post_valid && dt > 0 && dt < longint'(model_cfg.pot_win);
    dep = word.pre_valid && word.post_valid && dt < 0 && -dt < longint'(model_cfg.dep_win);
    res = wt;
    chg = 1'b0;
    sat = 1'b0;
    if (pot || dep) begin
      mag   = pot ? dt : -dt;
      term  = round_q20(longint'(pot ? model_cfg.pot_amp : model_cfg.dep_amp) *
                        decay_q20[mag]);
      delta = term;
      sgn   = pot ? 1 : -1;
      if (model_cfg.rule_mode == RULE_MULT) begin
        pw    = round_q20(wt * ((longint'(1) <<< FRAC_BITS) - wt));
        delta = round_q20(term * pw);
      end else if (model_cfg.rule_mode == RULE_ANTI) begin
        sgn = -sgn;
      end
      res = wt + sgn * delta;
      // pin a weight that crossed zero against the window's direction
      if (pot && wt > 0 && res < 0) res = longint'(model_cfg.sign_floor);
      if (dep && wt < 0 && res > 0) res = -longint'(model_cfg.sign_floor);
      if (res > WEIGHT_HI) begin
        res = WEIGHT_HI;
        sat = 1'b1;
      end
      if (res < WEIGHT_LO) begin
        res = WEIGHT_LO;
        sat = 1'b1;
      end
      chg = 1'b1;
    end
    upd.new_weight = res[WEIGHT_W-1:0];
    upd.changed    = chg;
    upd.saturated  = sat;
    return upd;
  endfunction

  function automatic stdp_in_t make_word(longint wt, longint pre, bit pv, longint post, bit qv);
    stdp_in_t word;
    word.weight          = wt[WEIGHT_W-1:0];
    word.pre_spike_time  = pre[TIME_W-1:0];
    word.pre_valid       = pv;
    word.post_spike_time = post[TIME_W-1:0];
    word.post_valid      = qv;
    return word;
  endfunction

  function automatic stdp_out_t make_res(longint wt, bit chg, bit sat);
    stdp_out_t upd;
    upd.new_weight = wt[WEIGHT_W-1:0];
    upd.changed    = chg;
    upd.saturated  = sat;
    return upd;
  endfunction

  function automatic void plan_reg(logic [CFG_INDEX_W-1:0] idx, longint val);
    plan_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val[CFG_DATA_W-1:0];
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_word(stdp_in_t word, bit typed, stdp_out_t upd);
    plan_row_t row;
    row           = '{default: '0};
    row.word      = word;
    row.typed     = typed;
    row.typed_res = upd;
    directed_plan.push_back(row);
  endfunction

  // Weight mix: full range, near zero, near the rails, around +/-1.0
  function automatic longint random_weight();
    longint wt;
    case ($urandom_range(0, 3))
      0: wt = $signed(24'($urandom()));
      1: wt = longint'($urandom_range(0, 8192)) - 4096;
      2: begin
        wt = longint'($urandom_range(0, 4095));
        wt = $urandom_range(0, 1) ? WEIGHT_HI - wt : WEIGHT_LO + wt;
      end
      default: begin
        wt = (longint'(1) <<< FRAC_BITS) + longint'($urandom_range(0, 65536)) - 32768;
        if ($urandom_range(0, 1)) wt = -wt;
      end
    endcase
    return wt;
  endfunction

  function automatic stdp_in_t random_word();
    int     kind, mag;
    longint pre, post;
    bit     pot_side;
    kind = $urandom_range(0, 99);
    pre  = $urandom_range(300, (1 << TIME_W) - 301);
    if (kind < 80) begin
      pot_side = 1'($urandom_range(0, 1));
      mag  = $urandom_range(1, int'(pot_side ? model_cfg.pot_win : model_cfg.dep_win) + 2);
      post = pot_side ? pre + mag : pre - mag;
      return make_word(random_weight(), pre, 1'b1, post, 1'b1);
    end else if (kind < 90) begin
      return make_word(random_weight(), $urandom_range(0, (1 << TIME_W) - 1),
                       1'($urandom_range(0, 1)), $urandom_range(0, (1 << TIME_W) - 1),
                       1'($urandom_range(0, 1)));
    end else begin
      // broken pair: coincident spikes or a missing neuron
      post = pre + $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0:       return make_word(random_weight(), pre, 1'b1, pre, 1'b1);
        1:       return make_word(random_weight(), pre, 1'b0, post, 1'b1);
        default: return make_word(random_weight(), pre, 1'b1, post, 1'b0);
      endcase
    end
  endfunction

  function automatic int pick_in(int lo, int hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RULE_MODE:  model_cfg.rule_mode  = val[MODE_W-1:0];
      REG_POT_AMP:    model_cfg.pot_amp    = val[AMP_W-1:0];
      REG_DEP_AMP:    model_cfg.dep_amp    = val[AMP_W-1:0];
      REG_POT_WIN:    model_cfg.pot_win    = val[WIN_W-1:0];
      REG_DEP_WIN:    model_cfg.dep_win    = val[WIN_W-1:0];
      REG_SIGN_FLOOR: model_cfg.sign_floor = val[FLOOR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(input stdp_in_t word, input bit typed, input stdp_out_t typed_res);
    stdp_out_t upd;
    bit        took;
    upd = typed ? typed_res : predict_update(word);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= word;
    // busy only moves on rising edges, so its mid-cycle value decides the edge
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    expected_updates.push_back(upd);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (done === 1'b1) begin
      if (expected_updates.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %0d",
                                  $signed(result.new_weight)));
      end else begin
        oldest_update = expected_updates.pop_front();
        if (result.new_weight !== oldest_update.new_weight)
          report_mismatch($sformatf("new_weight got %0d want %0d",
                                    $signed(result.new_weight),
                                    $signed(oldest_update.new_weight)));
        if (result.changed !== oldest_update.changed)
          report_mismatch($sformatf("changed got %b want %b",
                                    result.changed, oldest_update.changed));
        if (result.saturated !== oldest_update.saturated)
          report_mismatch($sformatf("saturated got %b want %b",
                                    result.saturated, oldest_update.saturated));
      end
    end
  end

  initial begin
    logic [63:0] e;
    bit          prev_item;

    e = 64'd1 << 32;
    for (int k = 0; k < DECAY_INDEX_COUNT; k++) begin
      decay_q20[k] = (k < DECAY_TABLE_DEPTH) ?
                     longint'((e + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS)) : 0;
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    model_cfg.rule_mode  = RST_RULE_MODE;
    model_cfg.pot_amp    = RST_POT_AMP;
    model_cfg.dep_amp    = RST_DEP_AMP;
    model_cfg.pot_win    = RST_POT_WIN;
    model_cfg.dep_win    = RST_DEP_WIN;
    model_cfg.sign_floor = RST_SIGN_FLOOR;

    // reset settings: missing neurons, coincident spikes, window edges, rails
    plan_word(make_word(longint'(24'h123456), 10, 1'b0, 20, 1'b1), 1'b1,
              make_res(longint'(24'h123456), 0, 0));
    plan_word(make_word(-5, 10, 1'b1, 20, 1'b0), 1'b1, make_res(-5, 0, 0));
    plan_word(make_word(WEIGHT_LO, 1048575, 1'b1, 1048575, 1'b1), 1'b1,
              make_res(WEIGHT_LO, 0, 0));
    plan_word(make_word(1000, 100, 1'b1, 175, 1'b1), 1'b1, make_res(1000, 0, 0));
    plan_word(make_word(1000, 300, 1'b1, 100, 1'b1), 1'b1, make_res(1000, 0, 0));
    plan_word(make_word(1000, 100, 1'b1, 174, 1'b1), 1'b0, '0);
    plan_word(make_word(1000, 299, 1'b1, 100, 1'b1), 1'b0, '0);
    plan_word(make_word(WEIGHT_HI, 0, 1'b1, 1, 1'b1), 1'b1, make_res(WEIGHT_HI, 1, 1));
    plan_word(make_word(WEIGHT_LO, 1, 1'b1, 0, 1'b1), 1'b1, make_res(WEIGHT_LO, 1, 1));
    plan_word(make_word(0, 0, 1'b1, 1048575, 1'b1), 1'b1, make_res(0, 0, 0));
    plan_word(make_word(1, 1048575, 1'b1, 0, 1'b1), 1'b1, make_res(1, 0, 0));
    plan_word(make_word(0, 5, 1'b1, 6, 1'b1), 1'b0, '0);
    // swapped signs push small weights across zero
    plan_reg(REG_RULE_MODE, longint'(RULE_ANTI));
    plan_word(make_word(1, 0, 1'b1, 1, 1'b1), 1'b1, make_res(105, 1, 0));
    plan_word(make_word(-1, 1, 1'b1, 0, 1'b1), 1'b1, make_res(-105, 1, 0));
    plan_word(make_word(WEIGHT_HI, 3, 1'b1, 0, 1'b1), 1'b1, make_res(WEIGHT_HI, 1, 1));
    plan_reg(REG_RULE_MODE, longint'(RULE_MULT));
    plan_word(make_word(1 << 19, 0, 1'b1, 2, 1'b1), 1'b0, '0);
    plan_word(make_word(WEIGHT_LO, 1, 1'b1, 0, 1'b1), 1'b0, '0);
    plan_word(make_word(WEIGHT_HI, 0, 1'b1, 1, 1'b1), 1'b0, '0);
    plan_reg(REG_RULE_MODE, 3);  // unused code, behaves as additive
    plan_word(make_word(1000, 20, 1'b1, 30, 1'b1), 1'b0, '0);
    plan_reg(REG_RULE_MODE, longint'(RULE_ADD));
    plan_reg(REG_POT_AMP, 1 << FRAC_BITS);
    plan_reg(REG_DEP_AMP, 1 << FRAC_BITS);
    plan_reg(REG_POT_WIN, 255);
    plan_reg(REG_DEP_WIN, 255);
    plan_reg(REG_SIGN_FLOOR, (1 << FLOOR_W) - 1);
    plan_word(make_word(0, 1000, 1'b1, 1254, 1'b1), 1'b0, '0);
    plan_word(make_word(0, 1254, 1'b1, 1000, 1'b1), 1'b0, '0);
    plan_word(make_word(100, 1, 1'b1, 0, 1'b1), 1'b0, '0);
    plan_word(make_word(-100, 0, 1'b1, 1, 1'b1), 1'b0, '0);
    // zero windows shut both sides off
    plan_reg(REG_POT_AMP, 0);
    plan_reg(REG_DEP_AMP, 0);
    plan_reg(REG_POT_WIN, 0);
    plan_reg(REG_DEP_WIN, 0);
    plan_reg(REG_SIGN_FLOOR, 0);
    plan_word(make_word(1234, 7, 1'b1, 8, 1'b1), 1'b1, make_res(1234, 0, 0));
    plan_word(make_word(1234, 8, 1'b1, 7, 1'b1), 1'b1, make_res(1234, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_item = 1'b0;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg) begin
        if (prev_item) drain_pipe();
        program_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
        prev_item = 1'b0;
      end else begin
        cfg_we <= 1'b0;
        send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].typed_res);
        prev_item = 1'b1;
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_pipe();
      program_reg(REG_RULE_MODE, CFG_DATA_W'(ph % 4));
      program_reg(REG_POT_AMP, CFG_DATA_W'(pick_in(0, 1 << FRAC_BITS)));
      program_reg(REG_DEP_AMP, CFG_DATA_W'(pick_in(0, 1 << FRAC_BITS)));
      program_reg(REG_POT_WIN, CFG_DATA_W'(pick_in(1, 255)));
      program_reg(REG_DEP_WIN, CFG_DATA_W'(pick_in(1, 255)));
      program_reg(REG_SIGN_FLOOR, CFG_DATA_W'(pick_in(0, (1 << FLOOR_W) - 1)));
      cfg_we <= 1'b0;
      case (ph % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 55;
        2:       idle_pct = 0;
        default: idle_pct = 18;
      endcase
      repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
    end

    drain_pipe();
    if (mismatch_count == 0) begin
      $display("stdp_weight_update_top_tb: PASS");
    end else begin
      $display("stdp_weight_update_top_tb: FAIL");
    end
    $finish;
  end

endmodule
